@@ hw/rtl/monochrome_framebuffer_draw_defines.svh @@
// assertion macros for the frame store drawing block
`ifndef MONOCHROME_FRAMEBUFFER_DRAW_DEFINES_SVH
`define MONOCHROME_FRAMEBUFFER_DRAW_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mfd_pkg.sv @@
package mfd_pkg;

    localparam int DispWidth  = 128;
    localparam int DispHeight = 64;
    localparam int Pages      = (DispHeight + 7) / 8;
    localparam int StoreDepth = 1024;
    localparam int AddrW      = 10;

    typedef enum logic [2:0] {
        FN_READ  = 3'd0,
        FN_PIXEL = 3'd1,
        FN_LINE  = 3'd2,
        FN_RECT  = 3'd3,
        FN_FILL  = 3'd4,
        FN_HSPAN = 3'd5,
        FN_VSPAN = 3'd6,
        FN_NONE  = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]       func;
        logic [7:0]       x_a;
        logic [7:0]       y_a;
        logic [7:0]       x_b;
        logic [7:0]       y_b;
        logic             pixel_on;
        logic [AddrW-1:0] read_address;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       was_read;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_LINE,
        ST_RECT_H,
        ST_RECT_V,
        ST_FILL,
        ST_HSPAN,
        ST_VSPAN,
        ST_DONE
    } t_state;

    // datapath commands from the controller
    typedef struct packed {
        logic load;        // capture command, set up walk
        logic clr_step;    // write zero at clear address, advance
        logic rd_issue;    // read byte at read address
        logic line_step;   // plot line pixel, advance
        logic rect_h_step; // plot top/bottom pair, advance x
        logic rect_v_init; // restart y walk at top
        logic rect_v_step; // plot left/right pair, advance y
        logic fill_step;   // plot one fill pixel, advance
        logic hspan_step;
        logic vspan_step;
        logic emit;        // present result
    } t_ctrl;

    // status from the datapath
    typedef struct packed {
        logic clr_last;
        logic line_last;
        logic rect_h_last;
        logic rect_v_last;
        logic fill_last;
        logic span_last;
        logic span_empty;
        logic wr_busy;     // second write of a pixel pair pending, or a pixel write in the pipe
    } t_stat;

endpackage

@@ hw/rtl/mfd_ctrl.sv @@
module mfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_func,
    input  mfd_pkg::t_stat i_stat,
    output mfd_pkg::t_ctrl o_ctrl,
    output logic          o_busy
);
    import mfd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    unique case (t_func'(i_func))
                        FN_READ:  n_state = ST_RD;
                        FN_PIXEL: n_state = ST_LINE;
                        FN_LINE:  n_state = ST_LINE;
                        FN_RECT:  n_state = ST_RECT_H;
                        FN_FILL:  n_state = ST_FILL;
                        FN_HSPAN: n_state = ST_HSPAN;
                        FN_VSPAN: n_state = ST_VSPAN;
                        FN_NONE:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                o_ctrl.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_RD: begin
                o_ctrl.rd_issue = 1'b1;
                n_state = ST_DONE;
            end
            ST_LINE: begin
                o_ctrl.line_step = 1'b1;
                if (i_stat.line_last) n_state = ST_DONE;
            end
            ST_RECT_H: begin
                if (i_stat.rect_h_last) begin
                    o_ctrl.rect_v_init = 1'b1;
                    n_state = ST_RECT_V;
                end else begin
                    o_ctrl.rect_h_step = 1'b1;
                end
            end
            ST_RECT_V: begin
                if (i_stat.rect_v_last) n_state = ST_DONE;
                else o_ctrl.rect_v_step = 1'b1;
            end
            ST_FILL: begin
                o_ctrl.fill_step = 1'b1;
                if (i_stat.fill_last) n_state = ST_DONE;
            end
            ST_HSPAN: begin
                if (i_stat.span_empty || i_stat.span_last) n_state = ST_DONE;
                else o_ctrl.hspan_step = 1'b1;
            end
            ST_VSPAN: begin
                if (i_stat.span_empty || i_stat.span_last) n_state = ST_DONE;
                else o_ctrl.vspan_step = 1'b1;
            end
            ST_DONE: begin
                if (!i_stat.wr_busy) begin
                    o_ctrl.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/mfd_datapath.sv @@
module mfd_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mfd_pkg::t_cmd   i_cmd,
    input  mfd_pkg::t_ctrl  i_ctrl,
    output mfd_pkg::t_stat  o_stat,
    output logic            o_done,
    output mfd_pkg::t_result o_result
);
    import mfd_pkg::*;

    // read-modify-write pixel pipe: stage a reads, stage b writes
    logic [7:0] r_mem [StoreDepth];

    t_cmd        r_cmd;
    logic [7:0]  r_x, r_y;       // walk coordinates
    logic [8:0]  r_i;            // run counter for rect and spans
    logic signed [10:0] r_err;
    logic [AddrW-1:0] r_clr;
    logic        r_pend2;        // second pixel of a pair still to issue
    logic [7:0]  r_px2, r_py2;

    // pixel request pipe
    logic             r_a_vld, r_b_vld;
    logic [AddrW-1:0] r_a_idx, r_b_idx;
    logic [2:0]       r_a_bit, r_b_bit;
    logic [7:0]       r_rd;

    logic             p_vld;
    logic [7:0]       p_x, p_y;
    logic [15:0]      p_idx_w;
    logic             p_ok;

    // line values
    logic [7:0] l_dx, l_dy;
    logic signed [11:0] l_e2;
    logic l_end, l_mx, l_my;

    logic [7:0] r_right, r_bottom;
    logic [8:0] rect_w_lim, rect_h_lim;

    logic [7:0] b_new;
    logic       n_pend2;

    // walk set-up taken at load, a pixel is a one-point line
    t_cmd       ld_cmd;
    logic [7:0] ld_x, ld_y;
    logic [8:0] ld_i;

    assign l_dx = (r_cmd.x_b > r_cmd.x_a) ? r_cmd.x_b - r_cmd.x_a : r_cmd.x_a - r_cmd.x_b;
    assign l_dy = (r_cmd.y_b > r_cmd.y_a) ? r_cmd.y_b - r_cmd.y_a : r_cmd.y_a - r_cmd.y_b;
    assign l_e2 = {r_err[10], r_err} <<< 1;
    assign l_end = (r_x == r_cmd.x_b) && (r_y == r_cmd.y_b);
    assign l_mx = l_e2 > -$signed({4'd0, l_dy});
    assign l_my = l_e2 < $signed({4'd0, l_dx});

    assign rect_w_lim = ({1'b0, r_cmd.x_b} < 9'd256 - {1'b0, r_cmd.x_a})
                        ? {1'b0, r_cmd.x_b} : 9'd256 - {1'b0, r_cmd.x_a};
    assign rect_h_lim = ({1'b0, r_cmd.y_b} < 9'd256 - {1'b0, r_cmd.y_a})
                        ? {1'b0, r_cmd.y_b} : 9'd256 - {1'b0, r_cmd.y_a};

    // pixel chosen this cycle
    always_comb begin
        p_vld = 1'b0;
        p_x   = r_x;
        p_y   = r_y;
        n_pend2 = r_pend2;
        if (r_pend2) begin
            p_vld = 1'b1;
            p_x = r_px2;
            p_y = r_py2;
            n_pend2 = 1'b0;
        end else if (i_ctrl.line_step || i_ctrl.fill_step || i_ctrl.hspan_step
                     || i_ctrl.vspan_step) begin
            p_vld = 1'b1;
        end else if (i_ctrl.rect_h_step || i_ctrl.rect_v_step) begin
            p_vld = 1'b1;
            n_pend2 = 1'b1;
        end
        p_idx_w = 16'(p_x) * 16'(Pages) + 16'(p_y >> 3);
        p_ok = p_vld && (32'(p_x) < DispWidth) && (32'(p_y) < DispHeight)
               && (32'(p_idx_w) < StoreDepth);
    end

    assign o_stat.clr_last    = (r_clr == AddrW'(StoreDepth - 1));
    assign o_stat.line_last   = l_end && !r_pend2;
    assign o_stat.rect_h_last = !r_pend2 && (r_i >= rect_w_lim);
    assign o_stat.rect_v_last = !r_pend2 && (r_i >= rect_h_lim);
    assign o_stat.fill_last   = (32'(r_x) == DispWidth - 1) && (32'(r_y) == DispHeight - 1);
    assign o_stat.span_empty  = 1'b0;
    assign o_stat.span_last   = r_i[8];
    assign o_stat.wr_busy     = r_pend2 || r_a_vld || r_b_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_pend2 <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_pend2 <= n_pend2;
            r_a_vld <= p_ok;
            r_b_vld <= r_a_vld;
            o_done  <= i_ctrl.emit;
            if (i_ctrl.clr_step) r_clr <= r_clr + 1'b1;
        end
    end

    // a read issued in ST_RD lands in r_rd for the emit cycle
    always_ff @(posedge i_clk) begin
        r_a_idx  <= p_idx_w[AddrW-1:0];
        r_a_bit  <= p_y[2:0];
        r_b_idx  <= r_a_idx;
        r_b_bit  <= r_a_bit;
        if (i_ctrl.clr_step) begin
            r_mem[r_clr] <= 8'd0;
        end else if (r_b_vld) begin
            r_mem[r_b_idx] <= b_new;
        end
        r_rd <= r_mem[i_ctrl.rd_issue ? r_cmd.read_address : r_a_idx];
        if (i_ctrl.emit) begin
            o_result.was_read  <= (r_cmd.func == FN_READ);
            o_result.read_data <= (r_cmd.func == FN_READ) ? r_rd : 8'd0;
        end
    end

    // forward a write still landing on the same byte
    logic [7:0] b_src;
    logic [7:0] r_wlast;
    logic [AddrW-1:0] r_wlast_idx;
    logic r_wlast_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wlast_vld <= 1'b0;
        else r_wlast_vld <= r_b_vld;
        r_wlast     <= b_new;
        r_wlast_idx <= r_b_idx;
    end
    always_comb begin
        b_src = r_rd;
        if (r_wlast_vld && r_wlast_idx == r_b_idx) b_src = r_wlast;
        b_new = r_cmd.pixel_on ? (b_src | (8'd1 << r_b_bit))
                               : (b_src & ~(8'd1 << r_b_bit));
    end

    always_comb begin
        ld_cmd = i_cmd;
        ld_x   = i_cmd.x_a;
        ld_y   = i_cmd.y_a;
        ld_i   = '0;
        if (t_func'(i_cmd.func) == FN_PIXEL) begin
            ld_cmd.x_b = i_cmd.x_a;
            ld_cmd.y_b = i_cmd.y_a;
        end
        if (t_func'(i_cmd.func) == FN_FILL) begin
            ld_x = '0;
            ld_y = '0;
        end
        if (t_func'(i_cmd.func) == FN_HSPAN)
            ld_i = (i_cmd.x_a > i_cmd.x_b) ? 9'h100
                 : 9'(9'h100 - {1'b0, i_cmd.x_b - i_cmd.x_a} - 9'd1);
        if (t_func'(i_cmd.func) == FN_VSPAN)
            ld_i = (i_cmd.y_a > i_cmd.y_b) ? 9'h100
                 : 9'(9'h100 - {1'b0, i_cmd.y_b - i_cmd.y_a} - 9'd1);
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= ld_cmd;
            r_x   <= ld_x;
            r_y   <= ld_y;
            r_i   <= ld_i;
            r_err <= 11'($signed({3'd0, (i_cmd.x_b > i_cmd.x_a ? i_cmd.x_b - i_cmd.x_a
                                         : i_cmd.x_a - i_cmd.x_b)})
                    - $signed({3'd0, (i_cmd.y_b > i_cmd.y_a ? i_cmd.y_b - i_cmd.y_a
                                       : i_cmd.y_a - i_cmd.y_b)}));
            r_right  <= 8'(i_cmd.x_a + i_cmd.x_b - 8'd1);
            r_bottom <= 8'(i_cmd.y_a + i_cmd.y_b - 8'd1);
        end
        if (i_ctrl.line_step && !r_pend2 && !l_end) begin
            if (l_mx) begin
                r_x <= (r_cmd.x_a < r_cmd.x_b) ? r_x + 8'd1 : r_x - 8'd1;
            end
            if (l_my) begin
                r_y <= (r_cmd.y_a < r_cmd.y_b) ? r_y + 8'd1 : r_y - 8'd1;
            end
            r_err <= 11'(r_err - (l_mx ? $signed({3'd0, l_dy}) : 11'sd0)
                     + (l_my ? $signed({3'd0, l_dx}) : 11'sd0));
        end
        if (i_ctrl.rect_h_step && !r_pend2) begin
            r_px2 <= r_x;
            r_py2 <= r_bottom;
            r_y   <= r_cmd.y_a;
        end
        if (i_ctrl.rect_h_step && r_pend2) begin
            r_x <= r_x + 8'd1;
            r_i <= r_i + 9'd1;
        end
        if (i_ctrl.rect_v_init) begin
            r_x <= r_cmd.x_a;
            r_y <= r_cmd.y_a;
            r_i <= '0;
        end
        if (i_ctrl.rect_v_step && !r_pend2) begin
            r_px2 <= r_right;
            r_py2 <= r_y;
        end
        if (i_ctrl.rect_v_step && r_pend2) begin
            r_y <= r_y + 8'd1;
            r_i <= r_i + 9'd1;
        end
        if (i_ctrl.fill_step) begin
            if (32'(r_x) == DispWidth - 1) begin
                r_x <= '0;
                r_y <= r_y + 8'd1;
            end else begin
                r_x <= r_x + 8'd1;
            end
        end
        if (i_ctrl.hspan_step) begin
            r_x <= r_x + 8'd1;
            r_i <= r_i + 9'd1;
        end
        if (i_ctrl.vspan_step) begin
            r_y <= r_y + 8'd1;
            r_i <= r_i + 9'd1;
        end
    end

endmodule

@@ hw/rtl/monochrome_framebuffer_draw.sv @@
// channel   | direction | handshake            | payload
// command   | in        | i_start while !o_busy | i_cmd (t_cmd)
// result    | out       | o_done, one cycle    | o_result (t_result)
//
// after reset the store is swept to zero, one byte a cycle, while o_busy is high
// a rectangle edge is drawn as pixel pairs, with runs clipped at 255; each command
// drains the read-modify-write pipe into the store before o_done
// results cannot be stalled: o_done is high for exactly one cycle
`include "monochrome_framebuffer_draw_defines.svh"

module monochrome_framebuffer_draw (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mfd_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output mfd_pkg::t_result  o_result
);
    import mfd_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    // controller sequences each drawing walk
    mfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_cmd.func),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (o_busy)
    );

    // datapath owns the store and the coordinate walkers
    mfd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // a result is presented only once the block is idle again
    `MFD_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "result while busy")
    `MFD_ASSERT_NEXT(a_emit_done, i_clk, i_rst_n, w_ctrl.emit, o_done, "emit without result")
    `MFD_ASSERT_IMP(a_emit_drained, i_clk, i_rst_n, w_ctrl.emit, !w_stat.wr_busy, "early result")

endmodule

@@ bench/monochrome_framebuffer_draw_checker.sv @@
module monochrome_framebuffer_draw_checker
    import mfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_reads_seen
);

    // shadow copy of the frame store
    logic [7:0] shadow_store [StoreDepth];
    t_result    expected_results [$];

    task automatic plot(input int x, input int y, input logic on);
        int idx;
        begin
            if (x < 0 || y < 0 || x >= DispWidth || y >= DispHeight) return;
            idx = x * Pages + (y >> 3);
            if (idx >= StoreDepth) return;
            shadow_store[idx][y & 7] = on;
        end
    endtask

    task automatic plot_line(input int x0, input int y0, input int x1, input int y1,
                             input logic on);
        int dx, dy, sx, sy, err, e2;
        begin
            dx  = x1 > x0 ? x1 - x0 : x0 - x1;
            dy  = y1 > y0 ? y1 - y0 : y0 - y1;
            sx  = x0 < x1 ? 1 : -1;
            sy  = y0 < y1 ? 1 : -1;
            err = dx - dy;
            forever begin
                plot(x0, y0, on);
                if (x0 == x1 && y0 == y1) break;
                e2 = err * 2;
                if (e2 > -dy) begin
                    err -= dy;
                    x0 += sx;
                end
                if (e2 < dx) begin
                    err += dx;
                    y0 += sy;
                end
            end
        end
    endtask

    task automatic apply_draw(input t_cmd c);
        t_result r;
        int      top, left, w, h, bottom, right;
        begin
            r = '0;
            case (t_func'(c.func))
                FN_READ: begin
                    r.read_data = shadow_store[c.read_address];
                    r.was_read  = 1'b1;
                end
                FN_PIXEL: plot(c.x_a, c.y_a, c.pixel_on);
                FN_LINE:  plot_line(c.x_a, c.y_a, c.x_b, c.y_b, c.pixel_on);
                FN_RECT: begin
                    top = c.y_a; left = c.x_a; w = c.x_b; h = c.y_b;
                    // far edges wrap modulo 256
                    bottom = (top + h - 1) & 8'hff;
                    right  = (left + w - 1) & 8'hff;
                    for (int x = left; x < left + w && x <= 255; x++) begin
                        plot(x, top, c.pixel_on);
                        plot(x, bottom, c.pixel_on);
                    end
                    for (int y = top; y < top + h && y <= 255; y++) begin
                        plot(left, y, c.pixel_on);
                        plot(right, y, c.pixel_on);
                    end
                end
                FN_FILL:
                    for (int y = 0; y < DispHeight; y++)
                        for (int x = 0; x < DispWidth; x++) plot(x, y, c.pixel_on);
                FN_HSPAN: for (int x = c.x_a; x <= c.x_b; x++) plot(x, c.y_a, c.pixel_on);
                FN_VSPAN: for (int y = c.y_a; y <= c.y_b; y++) plot(c.x_a, y, c.pixel_on);
                default: ;
            endcase
            expected_results.push_back(r);
        end
    endtask

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result e;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (shadow_store[k]) shadow_store[k] = '0;
            expected_results.delete();
            o_fail_count <= 0;
            o_reads_seen <= 0;
        end else begin
            // result before command: a draw accepted now cannot answer in the same cycle
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    errs++;
                end else begin
                    e = expected_results.pop_front();
                    if (i_result.read_data !== e.read_data) begin
                        $error("read_data expected %0h actual %0h", e.read_data,
                               i_result.read_data);
                        errs++;
                    end
                    if (i_result.was_read !== e.was_read) begin
                        $error("was_read expected %0b actual %0b", e.was_read,
                               i_result.was_read);
                        errs++;
                    end
                    if (e.was_read) o_reads_seen <= o_reads_seen + 1;
                end
            end
            if (i_start && !i_busy) apply_draw(i_cmd);
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

@@ bench/monochrome_framebuffer_draw_tb.sv @@
module monochrome_framebuffer_draw_tb;
    import mfd_pkg::*;

    localparam int NumRandom  = 1390;
    localparam int CycleLimit = 4_000_000;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;
    int      fail_count;
    int      pending;
    int      reads_seen;
    int      cycle_count = 0;
    int      cmds_sent = 0;
    int      fills_sent = 0;
    bit      quiet_tail = 1'b0;

    always #5 i_clk = ~i_clk;

    monochrome_framebuffer_draw u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    monochrome_framebuffer_draw_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_cmd       (i_cmd),
        .i_done      (o_done),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_reads_seen(reads_seen)
    );

    // watchdog, sized for fills, the reset sweep and long lines
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one transaction at the falling edge, hold until the block takes it;
    // start stays high into the next transaction unless an idle gap comes first
    task automatic issue(input t_cmd c);
        int gap;
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
                i_start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_cmd   <= c;
            i_start <= 1'b1;
            do @(posedge i_clk); while (o_busy);
            cmds_sent++;
            if (c.func == FN_FILL) fills_sent++;
            @(negedge i_clk);
        end
    endtask

    function automatic t_cmd make_cmd(input t_func f, input int xa, input int ya,
                                      input int xb, input int yb, input bit on,
                                      input int addr);
        t_cmd c;
        c.func = f; c.x_a = 8'(xa); c.y_a = 8'(ya); c.x_b = 8'(xb); c.y_b = 8'(yb);
        c.pixel_on = on; c.read_address = 10'(addr);
        return c;
    endfunction

    // a read of a byte near where a drawing landed, so set bits get seen
    function automatic int near_addr(input t_cmd c);
        return (int'(c.x_a) * Pages + (c.y_a >> 3) + $urandom_range(0, 3)) & 10'h3ff;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd        c;
        int          pick;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(t_cmd)-1:0];
        // coordinates mostly on screen, sometimes anywhere
        if ($urandom_range(0, 4) != 0) begin
            c.x_a = 8'($urandom_range(0, DispWidth - 1));
            c.y_a = 8'($urandom_range(0, DispHeight - 1));
            c.x_b = 8'($urandom_range(0, DispWidth - 1));
            c.y_b = 8'($urandom_range(0, DispHeight - 1));
        end
        pick = $urandom_range(0, 99);
        if      (pick < 30) c.func = FN_READ;
        else if (pick < 45) c.func = FN_PIXEL;
        else if (pick < 60) c.func = FN_LINE;
        else if (pick < 70) c.func = FN_RECT;
        else if (pick < 80) c.func = FN_HSPAN;
        else if (pick < 90) c.func = FN_VSPAN;
        else if (pick < 92) c.func = FN_NONE;
        else if (pick < 93) c.func = FN_FILL;
        else                c.func = FN_READ;
        // rectangles mostly small so they land on screen
        if (c.func == FN_RECT && $urandom_range(0, 3) != 0) begin
            c.x_b = 8'($urandom_range(0, 40));
            c.y_b = 8'($urandom_range(0, 40));
        end
        // pixels set more often than cleared, else the store stays empty
        if (c.func != FN_FILL && $urandom_range(0, 3) != 0) c.pixel_on = 1'b1;
        return c;
    endfunction

    initial begin
        t_cmd c;
        int   settle;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, edges off screen, every operation, special cases
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 0));
        issue(make_cmd(FN_PIXEL, 0, 0, 0, 0, 1, 0));
        issue(make_cmd(FN_PIXEL, 127, 63, 0, 0, 1, 0));
        issue(make_cmd(FN_PIXEL, 128, 5, 0, 0, 1, 0));    // off screen in x
        issue(make_cmd(FN_PIXEL, 5, 64, 0, 0, 1, 0));     // off screen in y
        issue(make_cmd(FN_PIXEL, 255, 255, 255, 255, 1, 1023));
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 1023));
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 127 * Pages + 7));
        issue(make_cmd(FN_LINE,  0, 0, 127, 63, 1, 0));
        issue(make_cmd(FN_LINE,  120, 2, 3, 60, 1, 0));
        issue(make_cmd(FN_LINE,  255, 0, 0, 255, 1, 0));
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 66));
        issue(make_cmd(FN_RECT,  10, 10, 20, 12, 1, 0));
        issue(make_cmd(FN_RECT,  30, 30, 0, 5, 1, 0));    // zero width wraps edge
        issue(make_cmd(FN_RECT,  250, 250, 255, 255, 1, 0));
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 10 * Pages + 1));
        issue(make_cmd(FN_HSPAN, 0, 40, 255, 0, 1, 0));   // end of 255
        issue(make_cmd(FN_HSPAN, 50, 41, 20, 0, 1, 0));   // start beyond end
        issue(make_cmd(FN_VSPAN, 90, 0, 0, 255, 1, 0));
        issue(make_cmd(FN_VSPAN, 91, 30, 0, 10, 1, 0));   // start beyond end
        issue(make_cmd(FN_NONE,  255, 255, 255, 255, 1, 1023));
        issue(make_cmd(FN_FILL,  0, 0, 0, 0, 1, 0));
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 511));
        issue(make_cmd(FN_FILL,  0, 0, 0, 0, 0, 0));
        issue(make_cmd(FN_READ,  0, 0, 0, 0, 0, 511));

        for (int n = 0; n < NumRandom; n++) begin
            if (n > NumRandom - 150) quiet_tail = 1'b1;
            c = random_cmd();
            issue(c);
            if (c.func != FN_READ && $urandom_range(0, 1) == 0)
                issue(make_cmd(FN_READ, 0, 0, 0, 0, 0, near_addr(c)));
        end
        i_start <= 1'b0;

        settle = 0;
        while (pending != 0) @(posedge i_clk);
        while (settle < 64) begin
            @(posedge i_clk);
            settle++;
        end
        $display("%0d commands sent, %0d reads checked, %0d screen fills", cmds_sent,
                 reads_seen, fills_sent);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
